### hw/rtl/prd_pkg.sv
// Shared constants, types and helpers of the pinhole ray direction pipeline.
package prd_pkg;

	localparam int COMPONENT_BITS_DEF = 16;
	localparam int COORD_BITS_DEF     = 16;

	// Normalized magnitude width: the peak lands in [2^29, 2^30).
	localparam int MAG_BITS   = 30;
	localparam int MAG_TOP    = MAG_BITS - 1;
	localparam int SQ_BITS    = 62;
	localparam int ROOT_BITS  = 31;
	localparam int ROOT_STEPS = 31;
	localparam int VEC_BITS   = 64;
	localparam int COEF_BITS  = 39;
	localparam logic signed [VEC_BITS-1:0] COEF_LIMIT = 64'sd274877906943;

	localparam int CFG_IDX_BITS = 3;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_FORWARD    = 3'd0,
		REG_RIGHT      = 3'd1,
		REG_UP         = 3'd2,
		REG_VIEW_SCALE = 3'd3,
		REG_FOCAL      = 3'd4,
		REG_INV_WIDTH  = 3'd5,
		REG_INV_HEIGHT = 3'd6,
		REG_ASPECT     = 3'd7
	} prd_reg_t;

	// Per-item payload that rides alongside the square root.
	typedef struct packed {
		logic [2:0][MAG_BITS-1:0] mag;
		logic [2:0]               neg;
		logic                     zero;
	} prd_side_t;

	function automatic logic signed [COEF_BITS-1:0] clamp_coef(input logic signed [VEC_BITS-1:0] v);
		logic signed [VEC_BITS-1:0] c;
		c = v;
		if (v > COEF_LIMIT) begin
			c = COEF_LIMIT;
		end else if (v < -COEF_LIMIT) begin
			c = -COEF_LIMIT;
		end
		return COEF_BITS'(c);
	endfunction

endpackage

### hw/rtl/prd_coef.sv
// Screen coordinate to camera-plane coefficients (three stages).
module prd_coef import prd_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  logic [COORD_BITS-1:0]       sx,
	input  logic [COORD_BITS-1:0]       sy,
	input  logic [24:0]                 inv_w,
	input  logic [24:0]                 inv_h,
	input  logic [15:0]                 aspect,
	input  logic [15:0]                 vscale,
	output logic                        out_valid,
	output logic signed [COEF_BITS-1:0] cx,
	output logic signed [COEF_BITS-1:0] cy
);

	localparam int PW = COORD_BITS + 25;
	localparam int TW = COORD_BITS + 27;
	localparam int W1 = TW - 12;
	localparam logic signed [TW-1:0] NDC_OFS = TW'(64'h1000_0000);

	logic [PW-1:0]          prodx, prody;
	logic signed [TW-1:0]   tx, ty;
	logic signed [W1-1:0]   ndcx_s1, ndcy_s1;
	logic                   vld_s1, vld_s2, vld_s3;
	logic signed [W1+16:0]  axp, cyp;
	logic signed [W1+4:0]   ax_s2;
	logic signed [W1+8:0]   cyr_s2;
	logic signed [W1+21:0]  cxp;
	logic signed [W1+13:0]  cxr;
	logic signed [VEC_BITS-1:0] cxw, cyw;
	logic signed [COEF_BITS-1:0] cx_s3, cy_s3;

	assign prodx = sx * inv_w;
	assign prody = sy * inv_h;
	assign tx    = $signed({1'b0, prodx, 1'b0}) - NDC_OFS;
	assign ty    = $signed({1'b0, prody, 1'b0}) - NDC_OFS;

	assign axp = ndcx_s1 * $signed({1'b0, aspect});
	assign cyp = ndcy_s1 * $signed({1'b0, vscale});
	assign cxp = ax_s2 * $signed({1'b0, vscale});
	assign cxr = (W1+14)'(cxp >>> 8);
	assign cxw = VEC_BITS'(cxr);
	assign cyw = VEC_BITS'(cyr_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ndcx_s1 <= W1'(tx >>> 12);
			ndcy_s1 <= W1'(ty >>> 12);
			ax_s2   <= (W1+5)'(axp >>> 12);
			cyr_s2  <= (W1+9)'(cyp >>> 8);
			cx_s3   <= clamp_coef(cxw);
			cy_s3   <= clamp_coef(cyw);
		end
	end

	assign out_valid = vld_s3;
	assign cx        = cx_s3;
	assign cy        = cy_s3;

endmodule

### hw/rtl/prd_combine.sv
// Basis combination: focal*forward + cx*right + cy*up per component.
module prd_combine import prd_pkg::*; #(
	parameter int COMPONENT_BITS = COMPONENT_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  logic signed [COEF_BITS-1:0]   cx,
	input  logic signed [COEF_BITS-1:0]   cy,
	input  logic [15:0]                   focal,
	input  logic [3*COMPONENT_BITS-1:0]   fwd,
	input  logic [3*COMPONENT_BITS-1:0]   rgt,
	input  logic [3*COMPONENT_BITS-1:0]   upv,
	output logic                          out_valid,
	output logic [2:0][VEC_BITS-1:0]      v
);

	localparam int CB = COMPONENT_BITS;

	logic signed [VEC_BITS-1:0] pf_s1 [3];
	logic signed [VEC_BITS-1:0] pr_s1 [3];
	logic signed [VEC_BITS-1:0] pu_s1 [3];
	logic [2:0][VEC_BITS-1:0]   v_s2;
	logic                       vld_s1, vld_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				pf_s1[i] <= $signed({1'b0, focal, 8'b0}) * $signed(fwd[i*CB +: CB]);
				pr_s1[i] <= cx * $signed(rgt[i*CB +: CB]);
				pu_s1[i] <= cy * $signed(upv[i*CB +: CB]);
				v_s2[i]  <= pf_s1[i] + pr_s1[i] + pu_s1[i];
			end
		end
	end

	assign out_valid = vld_s2;
	assign v         = v_s2;

endmodule

### hw/rtl/prd_norm.sv
// Magnitude, common normalizing shift and sum of squares (five stages).
module prd_norm import prd_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     in_valid,
	input  logic [2:0][VEC_BITS-1:0] v,
	output logic                     out_valid,
	output logic [SQ_BITS-1:0]       sum,
	output prd_side_t                side
);

	logic [2:0][VEC_BITS-2:0] mag_s1, mag_s2;
	logic [2:0]               neg_s1, neg_s2;
	logic [VEC_BITS-2:0]      orv;
	logic [5:0]               pos;
	logic [5:0]               pos_s2;
	logic                     zero_s2;
	prd_side_t                side_s3, side_s4, side_s5;
	prd_side_t                side_n;
	logic [2:0][2*MAG_BITS-1:0] sq_s4;
	logic [SQ_BITS-1:0]       sum_s5;
	logic                     vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;

	assign orv = mag_s1[0] | mag_s1[1] | mag_s1[2];

	// Highest set bit of the OR is the highest bit of the peak.
	always_comb begin
		pos = '0;
		for (int b = 0; b < VEC_BITS-1; b++) begin
			if (orv[b]) begin
				pos = 6'(b);
			end
		end
	end

	always_comb begin
		side_n.neg  = neg_s2;
		side_n.zero = zero_s2;
		for (int i = 0; i < 3; i++) begin
			if (pos_s2 >= 6'(MAG_TOP)) begin
				side_n.mag[i] = MAG_BITS'(mag_s2[i] >> (pos_s2 - 6'(MAG_TOP)));
			end else begin
				side_n.mag[i] = MAG_BITS'(mag_s2[i] << (6'(MAG_TOP) - pos_s2));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				neg_s1[i] <= v[i][VEC_BITS-1];
				mag_s1[i] <= v[i][VEC_BITS-1] ? (VEC_BITS-1)'(-$signed(v[i]))
				                               : v[i][VEC_BITS-2:0];
				sq_s4[i]  <= side_s3.mag[i] * side_s3.mag[i];
			end
			mag_s2  <= mag_s1;
			neg_s2  <= neg_s1;
			pos_s2  <= pos;
			zero_s2 <= (orv == '0);
			side_s3 <= side_n;
			side_s4 <= side_s3;
			side_s5 <= side_s4;
			sum_s5  <= SQ_BITS'(sq_s4[0]) + SQ_BITS'(sq_s4[1]) + SQ_BITS'(sq_s4[2]);
		end
	end

	assign out_valid = vld_s5;
	assign sum       = sum_s5;
	assign side      = side_s5;

endmodule

### hw/rtl/prd_isqrt.sv
// Integer square root, one result bit per pipeline stage.
module prd_isqrt import prd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  in_valid,
	input  logic [SQ_BITS-1:0]    sum,
	input  prd_side_t             side_in,
	output logic                  out_valid,
	output logic [ROOT_BITS-1:0]  root,
	output prd_side_t             side_out
);

	logic [SQ_BITS-1:0] rem_s  [ROOT_STEPS+1];
	logic [SQ_BITS-1:0] res_s  [ROOT_STEPS+1];
	prd_side_t          side_s [ROOT_STEPS+1];
	logic               vld_s  [ROOT_STEPS+1];

	assign rem_s[0]  = sum;
	assign res_s[0]  = '0;
	assign side_s[0] = side_in;
	assign vld_s[0]  = in_valid;

	for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_step
		localparam logic [SQ_BITS-1:0] BIT = SQ_BITS'(1) << (2*(ROOT_STEPS-1-k));
		logic [SQ_BITS-1:0] trial, rem_n, res_n;

		always_comb begin
			trial = res_s[k] + BIT;
			if (rem_s[k] >= trial) begin
				rem_n = rem_s[k] - trial;
				res_n = (res_s[k] >> 1) + BIT;
			end else begin
				rem_n = rem_s[k];
				res_n = res_s[k] >> 1;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= rem_n;
				res_s[k+1]  <= res_n;
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign out_valid = vld_s[ROOT_STEPS];
	assign root      = res_s[ROOT_STEPS][ROOT_BITS-1:0];
	assign side_out  = side_s[ROOT_STEPS];

endmodule

### hw/rtl/prd_div.sv
// Rounded division of each magnitude by the root, one quotient bit per stage.
module prd_div import prd_pkg::*; #(
	parameter int COMPONENT_BITS = COMPONENT_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  logic                           in_valid,
	input  logic [ROOT_BITS-1:0]           root,
	input  prd_side_t                      side,
	output logic                           out_valid,
	output logic [2:0][COMPONENT_BITS-1:0] dir
);

	localparam int CB    = COMPONENT_BITS;
	localparam int CF    = CB - 2;
	localparam int STEPS = CF + 1;
	localparam int NW    = MAG_BITS + CF + 1;
	localparam int RW    = ROOT_BITS + 1;

	logic [NW-1:0]            num [3];
	logic [2:0][RW-1:0]       rem_s  [STEPS+1];
	logic [2:0][CF:0]         low_s  [STEPS+1];
	logic [2:0][CF:0]         quo_s  [STEPS+1];
	logic [ROOT_BITS-1:0]     den_s  [STEPS+1];
	logic [2:0]               neg_s  [STEPS+1];
	logic                     zero_s [STEPS+1];
	logic                     vld_s  [STEPS+1];
	logic [2:0][CB-1:0]       dir_s;
	logic                     vld_o;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			num[i] = NW'({side.mag[i], {CF{1'b0}}}) + NW'(root[ROOT_BITS-1:1]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
			vld_o    <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
			vld_o    <= vld_s[STEPS];
		end
	end

	// Preload the remainder with the numerator bits above the quotient range.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				rem_s[0][i] <= RW'(num[i] >> (CF+1));
				low_s[0][i] <= num[i][CF:0];
				quo_s[0][i] <= '0;
			end
			den_s[0]  <= root;
			neg_s[0]  <= side.neg;
			zero_s[0] <= side.zero;
		end
	end

	for (genvar j = 0; j < STEPS; j++) begin : g_step
		logic [2:0][RW-1:0] rem_n;
		logic [2:0][CF:0]   quo_n;

		always_comb begin
			logic [RW-1:0] t;
			for (int i = 0; i < 3; i++) begin
				t = {rem_s[j][i][RW-2:0], low_s[j][i][CF-j]};
				if (t >= {1'b0, den_s[j]}) begin
					rem_n[i] = t - {1'b0, den_s[j]};
					quo_n[i] = {quo_s[j][i][CF-1:0], 1'b1};
				end else begin
					rem_n[i] = t;
					quo_n[i] = {quo_s[j][i][CF-1:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j+1] <= 1'b0;
			end else if (en) begin
				vld_s[j+1] <= vld_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j+1]  <= rem_n;
				quo_s[j+1]  <= quo_n;
				low_s[j+1]  <= low_s[j];
				den_s[j+1]  <= den_s[j];
				neg_s[j+1]  <= neg_s[j];
				zero_s[j+1] <= zero_s[j];
			end
		end
	end

	// Apply sign; a zero vector gives zero.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				if (zero_s[STEPS]) begin
					dir_s[i] <= '0;
				end else if (neg_s[STEPS][i]) begin
					dir_s[i] <= -CB'(quo_s[STEPS][i]);
				end else begin
					dir_s[i] <= CB'(quo_s[STEPS][i]);
				end
			end
		end
	end

	assign out_valid = vld_o;
	assign dir       = dir_s;

endmodule

### hw/rtl/pinhole_ray_direction.sv
// Top level of the pinhole camera primary ray direction pipeline.
//
// Usage: write the camera set-up on the cfg channel (cfg_index selects the
// register, cfg_data carries the value; cfg_ready is always high), then
// stream screen coordinates in on s_axis and take unit ray directions from
// m_axis, one direction per coordinate, in order.
// Throughput: one item per cycle while not stalled. Depth: COMPONENT_BITS + 43
// register stages. The length is set by the square root (one root bit per
// stage, 31 stages) and the divider (one quotient bit per stage per component).
// Stall: when m_axis_tready is low the finished item holds in the output
// register and one more item parks in a skid register; only then does the
// whole pipeline freeze and s_axis_tready drop. Nothing is lost or repeated.
// Reset: arst_n clears every valid bit and loads the register defaults
// (view_scale 106, focal_length 256, aspect_ratio 4096, others zero).
// Configure only while the pipeline is empty.
module pinhole_ray_direction import prd_pkg::*; #(
	parameter int COMPONENT_BITS = COMPONENT_BITS_DEF,
	parameter int COORD_BITS     = COORD_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// s_axis_tdata: screen_x, screen_y (low bits first), zero padded to bytes
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [((2*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
	// m_axis_tdata: dir_x, dir_y, dir_z (low bits first), zero padded to bytes
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [((3*COMPONENT_BITS+7)/8)*8-1:0] m_axis_tdata,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [((3*COMPONENT_BITS > 25) ? 3*COMPONENT_BITS : 25)-1:0] cfg_data
);

	localparam int CB    = COMPONENT_BITS;
	localparam int CW    = COORD_BITS;
	localparam int VW    = 3*CB;
	localparam int OUT_W = ((3*CB+7)/8)*8;

	// Camera set-up registers
	logic [VW-1:0] forward_q, right_q, up_q;
	logic [15:0]   view_scale_q, focal_q, aspect_q;
	logic [24:0]   inv_width_q, inv_height_q;
	logic [VW-1:0] cfg_vec;

	// Pipeline hand-offs
	logic                        en;
	logic                        coef_vld, comb_vld, norm_vld, root_vld, div_vld;
	logic signed [COEF_BITS-1:0] cx, cy;
	logic [2:0][VEC_BITS-1:0]    vsum;
	logic [SQ_BITS-1:0]          sq_sum;
	prd_side_t                   side_n, side_r;
	logic [ROOT_BITS-1:0]        root;
	logic [2:0][CB-1:0]          dir;

	// Output register and skid
	logic                        out_vld_q, skid_vld_q;
	logic [2:0][CB-1:0]          out_dir_q, skid_dir_q;

	// Vector bits past bit 63 of cfg_data are dropped and read as zero.
	for (genvar b = 0; b < VW; b++) begin : g_vec
		if (b < 64) begin : g_keep
			assign cfg_vec[b] = cfg_data[b];
		end else begin : g_drop
			assign cfg_vec[b] = 1'b0;
		end
	end

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			forward_q    <= '0;
			right_q      <= '0;
			up_q         <= '0;
			view_scale_q <= 16'd106;
			focal_q      <= 16'd256;
			inv_width_q  <= '0;
			inv_height_q <= '0;
			aspect_q     <= 16'd4096;
		end else if (cfg_valid) begin
			unique case (prd_reg_t'(cfg_index))
				REG_FORWARD:    forward_q    <= cfg_vec;
				REG_RIGHT:      right_q      <= cfg_vec;
				REG_UP:         up_q         <= cfg_vec;
				REG_VIEW_SCALE: view_scale_q <= cfg_data[15:0];
				REG_FOCAL:      focal_q      <= cfg_data[15:0];
				REG_INV_WIDTH:  inv_width_q  <= cfg_data[24:0];
				REG_INV_HEIGHT: inv_height_q <= cfg_data[24:0];
				REG_ASPECT:     aspect_q     <= cfg_data[15:0];
			endcase
		end
	end

	// Advance the whole pipeline while the skid register is free.
	assign en            = !skid_vld_q;
	assign s_axis_tready = en;

	prd_coef #(.COORD_BITS(CW)) u_coef (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (s_axis_tvalid),
		.sx        (s_axis_tdata[CW-1:0]),
		.sy        (s_axis_tdata[2*CW-1:CW]),
		.inv_w     (inv_width_q),
		.inv_h     (inv_height_q),
		.aspect    (aspect_q),
		.vscale    (view_scale_q),
		.out_valid (coef_vld),
		.cx        (cx),
		.cy        (cy)
	);

	prd_combine #(.COMPONENT_BITS(CB)) u_combine (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (coef_vld),
		.cx        (cx),
		.cy        (cy),
		.focal     (focal_q),
		.fwd       (forward_q),
		.rgt       (right_q),
		.upv       (up_q),
		.out_valid (comb_vld),
		.v         (vsum)
	);

	prd_norm u_norm (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (comb_vld),
		.v         (vsum),
		.out_valid (norm_vld),
		.sum       (sq_sum),
		.side      (side_n)
	);

	prd_isqrt u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (norm_vld),
		.sum       (sq_sum),
		.side_in   (side_n),
		.out_valid (root_vld),
		.root      (root),
		.side_out  (side_r)
	);

	prd_div #(.COMPONENT_BITS(CB)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (root_vld),
		.root      (root),
		.side      (side_r),
		.out_valid (div_vld),
		.dir       (dir)
	);

	// Output register with a one-item skid behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (m_axis_tready || !out_vld_q) begin
			out_vld_q  <= skid_vld_q || div_vld;
			skid_vld_q <= 1'b0;
		end else if (div_vld && en) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (m_axis_tready || !out_vld_q) begin
			out_dir_q <= skid_vld_q ? skid_dir_q : dir;
		end else if (div_vld && en) begin
			skid_dir_q <= dir;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = OUT_W'(out_dir_q);

endmodule
